// ===== design/scc_pkg.sv =====
package scc_pkg;

    localparam int ROW_WIDTH   = 10;
    localparam int BOARD_ROWS  = 3;
    localparam int BOARD_CELLS = BOARD_ROWS * ROW_WIDTH;
    localparam int CELL_W      = 5;
    localparam int POS_W       = $clog2(BOARD_CELLS);

    typedef logic [2:0]        opcode_t;
    typedef logic [1:0]        kind_t;
    typedef logic [2:0]        err_t;
    typedef logic [3:0]        col_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam opcode_t OP_LOAD  = 3'd0;
    localparam opcode_t OP_BUILD = 3'd1;
    localparam opcode_t OP_ENC   = 3'd2;
    localparam opcode_t OP_DEC   = 3'd3;
    localparam opcode_t OP_CLEAR = 3'd4;

    localparam kind_t KIND_DIGIT  = 2'd0;
    localparam kind_t KIND_LETTER = 2'd1;
    localparam kind_t KIND_ERROR  = 2'd2;

    localparam err_t ERR_NONE       = 3'd0;
    localparam err_t ERR_NOT_LETTER = 3'd1;
    localparam err_t ERR_REPEATED   = 3'd2;
    localparam err_t ERR_BLANK_CELL = 3'd3;
    localparam err_t ERR_NOT_BUILT  = 3'd4;
    localparam err_t ERR_EQUAL_COLS = 3'd5;

    localparam logic [3:0] REG_BLANK_ONE = 4'd0;
    localparam logic [3:0] REG_BLANK_TWO = 4'd1;

    localparam cell_t CELL_BLANK = 5'd30;
    localparam cell_t CELL_PAD   = 5'd31;

    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;

    localparam col_t COL_MAX       = 4'(ROW_WIDTH - 1);
    localparam col_t RESET_COL_ONE = 4'd2;
    localparam col_t RESET_COL_TWO = 4'd7;

endpackage

// ===== design/scc_item_if.sv =====
interface scc_item_if;
    import scc_pkg::*;

    logic       valid;
    logic       ready;
    opcode_t    opcode;
    logic [7:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);

endinterface

// ===== design/scc_result_if.sv =====
interface scc_result_if;
    import scc_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      result_kind;
    logic [7:0] result_value;
    err_t       error_code;
    logic       last_of_run;

    modport source (output valid, output result_kind, output result_value,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input result_value,
                    input error_code, input last_of_run, output ready);

endinterface

// ===== design/scc_cfg_if.sv =====
interface scc_cfg_if;

    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ===== design/straddling_checkerboard_cipher_unit.sv =====
// Channel   Dir  Payload                                              Transfer
// item      in   opcode[2:0], symbol[7:0]                             valid & ready
// result    out  result_kind[1:0], result_value[7:0], error_code[2:0],
//                last_of_run                                          valid & ready
// cfg       in   index[3:0], data[3:0]                                valid & ready
//
// Load, clear and prefix digits finish when accepted. Encrypt reads the position memory and
// decrypt the board memory before the result register; errors also go to that register.
// Build walks the 30 board cells one per cycle; two-digit encrypt sends a second digit.
// rst_n clears control state; board and position memories are only valid after a build writes them.
// item.ready is low while an item is in work or its result waits for the result
// register; a stalled result register holds its transfer and blocks new results.
module straddling_checkerboard_cipher_unit
    import scc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic         clk,
    input  logic         rst_n,
    scc_item_if.sink     item,
    scc_result_if.source result,
    scc_cfg_if.sink      cfg
);

    localparam int LIDX_W = $clog2(ALPHABET_SIZE);
    localparam int KCNT_W = $clog2(ALPHABET_SIZE + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BUILD  = 3'd1;
    localparam logic [2:0] ST_ENC    = 3'd2;
    localparam logic [2:0] ST_DEC    = 3'd3;
    localparam logic [2:0] ST_SECOND = 3'd4;
    localparam logic [2:0] ST_ERR    = 3'd5;

    logic [2:0]               state_reg, state_next;
    col_t                     col1_reg, col1_next;
    col_t                     col2_reg, col2_next;
    logic [ALPHABET_SIZE-1:0] used_reg, used_next;
    logic [KCNT_W-1:0]        key_count_reg, key_count_next;
    logic                     built_reg, built_next;
    logic [1:0]               pending_reg, pending_next;
    err_t                     err_reg, err_next;
    col_t                     second_reg, second_next;
    pos_t                     pos_reg, pos_next;
    logic [KCNT_W-1:0]        key_idx_reg, key_idx_next;
    logic [ALPHABET_SIZE-1:0] remain_reg, remain_next;

    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg;
    logic [7:0] out_value_reg;
    err_t       out_err_reg;
    logic       out_last_reg;

    // memories
    logic [LIDX_W-1:0] key_mem [ALPHABET_SIZE];
    pos_t              pos_mem [ALPHABET_SIZE];
    cell_t             board_mem [BOARD_CELLS];

    logic              key_wr_en;
    logic [LIDX_W-1:0] key_wr_addr;
    logic [LIDX_W-1:0] key_wr_data;
    logic              key_rd_en;
    logic [LIDX_W-1:0] key_rd_reg;

    logic              pos_wr_en;
    logic [LIDX_W-1:0] pos_wr_addr;
    pos_t              pos_wr_data;
    logic              pos_rd_en;
    logic [LIDX_W-1:0] pos_rd_addr;
    pos_t              pos_rd_reg;

    logic              board_wr_en;
    pos_t              board_wr_addr;
    cell_t             board_wr_data;
    logic              board_rd_en;
    pos_t              board_rd_addr;
    cell_t             board_rd_reg;

    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_value;
    err_t       res_err;
    logic       res_last;
    logic       out_free;
    logic       push;

    logic              item_fire, cfg_fire;
    col_t              c1, c2;
    logic [7:0]        lc_off, uc_off;
    logic              is_lc, is_uc, is_letter;
    logic [LIDX_W-1:0] li;
    col_t              digit;

    logic                     cell_blank;
    logic                     key_take;
    logic [ALPHABET_SIZE-1:0] alpha_low;
    logic [LIDX_W-1:0]        alpha_idx;
    cell_t                    build_cell;
    pos_t                     enc_col_full;
    logic [1:0]               enc_row;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign c1 = (col1_reg > COL_MAX) ? COL_MAX : col1_reg;
    assign c2 = (col2_reg > COL_MAX) ? COL_MAX : col2_reg;

    assign lc_off    = item.symbol - ASCII_LOWER_A;
    assign uc_off    = item.symbol - ASCII_UPPER_A;
    assign is_lc     = (item.symbol >= ASCII_LOWER_A) && (lc_off < 8'(ALPHABET_SIZE));
    assign is_uc     = (item.symbol >= ASCII_UPPER_A) && (item.symbol <= ASCII_UPPER_Z)
                       && (uc_off < 8'(ALPHABET_SIZE));
    assign is_letter = is_lc || is_uc;
    assign li        = is_lc ? lc_off[LIDX_W-1:0] : uc_off[LIDX_W-1:0];
    assign digit     = item.symbol[3:0];

    // lowest unused letter: isolate lowest set bit, then encode
    assign alpha_low = remain_reg & (~remain_reg + 1'b1);
    always_comb
    begin
        alpha_idx = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if (alpha_low[i])
            begin
                alpha_idx = alpha_idx | LIDX_W'(i);
            end
        end
    end

    assign cell_blank = (pos_reg < pos_t'(ROW_WIDTH))
                        && ((pos_reg[3:0] == c1) || (pos_reg[3:0] == c2));
    assign key_take   = !cell_blank && (key_idx_reg < key_count_reg);

    always_comb
    begin
        if (cell_blank)
        begin
            build_cell = CELL_BLANK;
        end
        else if (key_take)
        begin
            build_cell = cell_t'(key_rd_reg);
        end
        else if (remain_reg != '0)
        begin
            build_cell = cell_t'(alpha_idx);
        end
        else
        begin
            build_cell = CELL_PAD;
        end
    end

    always_comb
    begin
        if (pos_rd_reg >= pos_t'(2 * ROW_WIDTH))
        begin
            enc_row      = 2'd2;
            enc_col_full = pos_rd_reg - pos_t'(2 * ROW_WIDTH);
        end
        else if (pos_rd_reg >= pos_t'(ROW_WIDTH))
        begin
            enc_row      = 2'd1;
            enc_col_full = pos_rd_reg - pos_t'(ROW_WIDTH);
        end
        else
        begin
            enc_row      = 2'd0;
            enc_col_full = pos_rd_reg;
        end
    end

    assign out_free = !out_valid_reg || result.ready;
    assign push     = res_valid && out_free;

    always_comb
    begin
        state_next     = state_reg;
        col1_next      = col1_reg;
        col2_next      = col2_reg;
        used_next      = used_reg;
        key_count_next = key_count_reg;
        built_next     = built_reg;
        pending_next   = pending_reg;
        err_next       = err_reg;
        second_next    = second_reg;
        pos_next       = pos_reg;
        key_idx_next   = key_idx_reg;
        remain_next    = remain_reg;

        res_valid = 1'b0;
        res_kind  = KIND_DIGIT;
        res_value = '0;
        res_err   = ERR_NONE;
        res_last  = 1'b1;

        key_wr_en     = 1'b0;
        key_wr_addr   = key_count_reg[LIDX_W-1:0];
        key_wr_data   = li;
        pos_wr_en     = 1'b0;
        pos_wr_addr   = build_cell[LIDX_W-1:0];
        pos_wr_data   = pos_reg;
        pos_rd_en     = 1'b0;
        pos_rd_addr   = li;
        board_wr_en   = 1'b0;
        board_wr_addr = pos_reg;
        board_wr_data = build_cell;
        board_rd_en   = 1'b0;
        board_rd_addr = pos_t'(digit);

        case (state_reg)
            ST_IDLE:
            begin
                key_idx_next = '0;
                if (item_fire)
                begin
                    case (item.opcode)
                        OP_LOAD:
                        begin
                            built_next   = 1'b0;
                            pending_next = 2'd0;
                            if (!is_letter)
                            begin
                                err_next   = ERR_NOT_LETTER;
                                state_next = ST_ERR;
                            end
                            else if (used_reg[li])
                            begin
                                err_next   = ERR_REPEATED;
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                if (key_count_reg < KCNT_W'(ALPHABET_SIZE))
                                begin
                                    key_wr_en      = 1'b1;
                                    key_count_next = key_count_reg + 1'b1;
                                end
                                used_next[li] = 1'b1;
                            end
                        end
                        OP_BUILD:
                        begin
                            if (c1 == c2)
                            begin
                                built_next   = 1'b0;
                                pending_next = 2'd0;
                                err_next     = ERR_EQUAL_COLS;
                                state_next   = ST_ERR;
                            end
                            else
                            begin
                                // board is rewritten in place; not usable until the pass ends
                                built_next  = 1'b0;
                                pos_next    = '0;
                                remain_next = ~used_reg;
                                state_next  = ST_BUILD;
                            end
                        end
                        OP_ENC:
                        begin
                            if (!built_reg)
                            begin
                                err_next   = ERR_NOT_BUILT;
                                state_next = ST_ERR;
                            end
                            else if (!is_letter)
                            begin
                                err_next   = ERR_NOT_LETTER;
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                pos_rd_en  = 1'b1;
                                state_next = ST_ENC;
                            end
                        end
                        OP_DEC:
                        begin
                            if (!built_reg)
                            begin
                                err_next   = ERR_NOT_BUILT;
                                state_next = ST_ERR;
                            end
                            else if (item.symbol >= 8'(ROW_WIDTH))
                            begin
                                pending_next = 2'd0;
                                err_next     = ERR_NOT_LETTER;
                                state_next   = ST_ERR;
                            end
                            else if (pending_reg == 2'd0)
                            begin
                                if (digit == c1)
                                begin
                                    pending_next = 2'd1;
                                end
                                else if (digit == c2)
                                begin
                                    pending_next = 2'd2;
                                end
                                else
                                begin
                                    board_rd_en = 1'b1;
                                    state_next  = ST_DEC;
                                end
                            end
                            else
                            begin
                                board_rd_en   = 1'b1;
                                board_rd_addr = (pending_reg == 2'd2)
                                    ? pos_t'(2 * ROW_WIDTH) + pos_t'(digit)
                                    : pos_t'(ROW_WIDTH) + pos_t'(digit);
                                pending_next  = 2'd0;
                                state_next    = ST_DEC;
                            end
                        end
                        OP_CLEAR:
                        begin
                            used_next      = '0;
                            key_count_next = '0;
                            built_next     = 1'b0;
                            pending_next   = 2'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                board_wr_en = 1'b1;
                pos_wr_en   = (build_cell < cell_t'(ALPHABET_SIZE));
                if (key_take)
                begin
                    key_idx_next = key_idx_reg + 1'b1;
                end
                else if (!cell_blank)
                begin
                    remain_next = remain_reg & ~alpha_low;
                end
                pos_next = pos_reg + 1'b1;
                if (pos_reg == pos_t'(BOARD_CELLS - 1))
                begin
                    built_next   = 1'b1;
                    pending_next = 2'd0;
                    state_next   = ST_IDLE;
                end
            end
            ST_ENC:
            begin
                res_valid   = 1'b1;
                second_next = enc_col_full[3:0];
                if (enc_row == 2'd0)
                begin
                    res_value = 8'(enc_col_full[3:0]);
                    if (push)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    res_value = 8'((enc_row == 2'd1) ? c1 : c2);
                    res_last  = 1'b0;
                    if (push)
                    begin
                        state_next = ST_SECOND;
                    end
                end
            end
            ST_SECOND:
            begin
                res_valid = 1'b1;
                res_value = 8'(second_reg);
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC:
            begin
                res_valid = 1'b1;
                if (board_rd_reg >= cell_t'(ALPHABET_SIZE))
                begin
                    res_kind = KIND_ERROR;
                    res_err  = ERR_BLANK_CELL;
                end
                else
                begin
                    res_kind  = KIND_LETTER;
                    res_value = ASCII_LOWER_A + 8'(board_rd_reg);
                end
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_err   = err_reg;
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // config only while idle: user's rule, unenforced; a column write drops the board
        if (cfg_fire)
        begin
            if (cfg.index == REG_BLANK_ONE)
            begin
                col1_next    = cfg.data;
                built_next   = 1'b0;
                pending_next = 2'd0;
            end
            else if (cfg.index == REG_BLANK_TWO)
            begin
                col2_next    = cfg.data;
                built_next   = 1'b0;
                pending_next = 2'd0;
            end
        end
    end

    // key read runs ahead one step so the build sees key[key_idx] each cycle
    assign key_rd_en = (key_idx_next < KCNT_W'(ALPHABET_SIZE));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col1_reg      <= RESET_COL_ONE;
            col2_reg      <= RESET_COL_TWO;
            used_reg      <= '0;
            key_count_reg <= '0;
            built_reg     <= 1'b0;
            pending_reg   <= 2'd0;
            key_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col1_reg      <= col1_next;
            col2_reg      <= col2_next;
            used_reg      <= used_next;
            key_count_reg <= key_count_next;
            built_reg     <= built_next;
            pending_reg   <= pending_next;
            key_idx_reg   <= key_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        second_reg <= second_next;
        pos_reg    <= pos_next;
        remain_reg <= remain_next;
        if (push)
        begin
            out_kind_reg  <= res_kind;
            out_value_reg <= res_value;
            out_err_reg   <= res_err;
            out_last_reg  <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        if (key_rd_en)
        begin
            key_rd_reg <= key_mem[key_idx_next[LIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_wr_en)
        begin
            pos_mem[pos_wr_addr] <= pos_wr_data;
        end
        if (pos_rd_en)
        begin
            pos_rd_reg <= pos_mem[pos_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (board_wr_en)
        begin
            board_mem[board_wr_addr] <= board_wr_data;
        end
        if (board_rd_en)
        begin
            board_rd_reg <= board_mem[board_rd_addr];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.result_value = out_value_reg;
    assign result.error_code   = out_err_reg;
    assign result.last_of_run  = out_last_reg;

    a_built_cols_differ: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg |-> (c1 != c2))
        else $error("board built with equal blank columns");

    a_key_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg == KCNT_W'($countones(used_reg)))
        else $error("key count out of step with used letters");

    a_pending_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("illegal pending row");

    a_prefix_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !res_last) |=> (state_reg == ST_SECOND))
        else $error("prefix digit not followed by column digit");

    a_build_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> !built_reg)
        else $error("board marked built during build pass");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import scc_pkg::*;

    localparam int LETTERS = 26;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        err_t       err;
        logic       last;
    } cipher_out_t;

    logic clk = 1'b0;
    logic rst_n;

    scc_item_if   item_ch ();
    scc_result_if result_ch ();
    scc_cfg_if    cfg_ch ();

    straddling_checkerboard_cipher_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted state of the cipher
    col_t        blank_one_reg;
    col_t        blank_two_reg;
    logic [25:0] used_mask;
    logic [4:0]  key_seq [LETTERS];
    int          key_len;
    cell_t       board [BOARD_CELLS];
    logic [4:0]  where_on_board [LETTERS];
    logic        board_ready;
    logic [1:0]  prefix_row;

    cipher_out_t cipher_out_q [$];
    int          bad_count;
    int          items_sent;
    logic        steady;

    function automatic int letter_of(logic [7:0] s);
        if (s >= ASCII_LOWER_A && s < ASCII_LOWER_A + 8'(LETTERS))
            return int'(s - ASCII_LOWER_A);
        if (s >= ASCII_UPPER_A && s <= ASCII_UPPER_Z)
            return int'(s - ASCII_UPPER_A);
        return -1;
    endfunction

    function automatic col_t col_clip(col_t c);
        return (c > COL_MAX) ? COL_MAX : c;
    endfunction

    function automatic void push_out(kind_t k, logic [7:0] v, err_t e, logic l);
        cipher_out_t r;
        r.kind  = k;
        r.value = v;
        r.err   = e;
        r.last  = l;
        cipher_out_q.push_back(r);
    endfunction

    function automatic void drop_board();
        board_ready = 1'b0;
        prefix_row  = 2'd0;
    endfunction

    function automatic void fill_board(col_t c1, col_t c2);
        int next_key = 0;
        int next_alpha = 0;
        for (int p = 0; p < BOARD_CELLS; p++)
        begin
            if (p < ROW_WIDTH && (p == c1 || p == c2))
            begin
                board[p] = CELL_BLANK;
                continue;
            end
            if (next_key < key_len)
            begin
                board[p] = key_seq[next_key];
                next_key++;
            end
            else
            begin
                while (next_alpha < LETTERS && used_mask[next_alpha])
                    next_alpha++;
                if (next_alpha < LETTERS)
                begin
                    board[p] = cell_t'(next_alpha);
                    next_alpha++;
                end
                else
                    board[p] = CELL_PAD;
            end
            if (board[p] < LETTERS)
                where_on_board[board[p]] = 5'(p);
        end
        board_ready = 1'b1;
        prefix_row  = 2'd0;
    endfunction

    function automatic void checkerboard_step(opcode_t op, logic [7:0] sym);
        int    li;
        int    p;
        int    row;
        int    col;
        col_t  c1;
        col_t  c2;
        cell_t cell_val;
        li = letter_of(sym);
        c1 = col_clip(blank_one_reg);
        c2 = col_clip(blank_two_reg);
        case (op)
            OP_LOAD:
            begin
                drop_board();
                if (li < 0)
                    push_out(KIND_ERROR, 8'd0, ERR_NOT_LETTER, 1'b1);
                else if (used_mask[li])
                    push_out(KIND_ERROR, 8'd0, ERR_REPEATED, 1'b1);
                else
                begin
                    if (key_len < LETTERS)
                    begin
                        key_seq[key_len] = 5'(li);
                        key_len++;
                    end
                    used_mask[li] = 1'b1;
                end
            end
            OP_BUILD:
            begin
                if (c1 == c2)
                begin
                    drop_board();
                    push_out(KIND_ERROR, 8'd0, ERR_EQUAL_COLS, 1'b1);
                end
                else
                    fill_board(c1, c2);
            end
            OP_ENC:
            begin
                if (!board_ready)
                    push_out(KIND_ERROR, 8'd0, ERR_NOT_BUILT, 1'b1);
                else if (li < 0)
                    push_out(KIND_ERROR, 8'd0, ERR_NOT_LETTER, 1'b1);
                else
                begin
                    p   = where_on_board[li] % BOARD_CELLS;
                    row = p / ROW_WIDTH;
                    col = p % ROW_WIDTH;
                    if (row == 0)
                        push_out(KIND_DIGIT, 8'(col), ERR_NONE, 1'b1);
                    else
                    begin
                        push_out(KIND_DIGIT, 8'((row == 1) ? c1 : c2), ERR_NONE, 1'b0);
                        push_out(KIND_DIGIT, 8'(col), ERR_NONE, 1'b1);
                    end
                end
            end
            OP_DEC:
            begin
                if (!board_ready)
                    push_out(KIND_ERROR, 8'd0, ERR_NOT_BUILT, 1'b1);
                else if (sym >= ROW_WIDTH)
                begin
                    prefix_row = 2'd0;
                    push_out(KIND_ERROR, 8'd0, ERR_NOT_LETTER, 1'b1);
                end
                else if (prefix_row == 2'd0 && sym == c1)
                    prefix_row = 2'd1;
                else if (prefix_row == 2'd0 && sym == c2)
                    prefix_row = 2'd2;
                else
                begin
                    cell_val   = board[(prefix_row % 3) * ROW_WIDTH + sym];
                    prefix_row = 2'd0;
                    if (cell_val >= LETTERS)
                        push_out(KIND_ERROR, 8'd0, ERR_BLANK_CELL, 1'b1);
                    else
                        push_out(KIND_LETTER, ASCII_LOWER_A + 8'(cell_val), ERR_NONE, 1'b1);
                end
            end
            OP_CLEAR:
            begin
                used_mask = '0;
                key_len   = 0;
                drop_board();
            end
            default: ;
        endcase
    endfunction

    // result side: random stalls, checked against the oldest prediction
    always @(negedge clk)
        result_ch.ready <= steady || ($urandom_range(99) >= 15);

    always @(posedge clk)
    begin
        cipher_out_t want;
        cipher_out_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.kind  = result_ch.result_kind;
            got.value = result_ch.result_value;
            got.err   = result_ch.error_code;
            got.last  = result_ch.last_of_run;
            if (cipher_out_q.size() == 0)
            begin
                $display("%0t: unexpected transfer: actual kind=%0d value=%0d err=%0d last=%0b",
                         $time, got.kind, got.value, got.err, got.last);
                bad_count++;
            end
            else
            begin
                want = cipher_out_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected kind=%0d value=%0d err=%0d last=%0b, actual kind=%0d value=%0d err=%0d last=%0b",
                             $time, want.kind, want.value, want.err, want.last,
                             got.kind, got.value, got.err, got.last);
                    bad_count++;
                end
            end
        end
    end

    task automatic send_item(opcode_t op, logic [7:0] sym);
        while (!steady && $urandom_range(99) < 15)
            @(negedge clk);
        item_ch.valid  = 1'b1;
        item_ch.opcode = op;
        item_ch.symbol = sym;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        checkerboard_step(op, sym);
        if (op <= OP_CLEAR)
            items_sent++;
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    // wait out every pending result, then the longest silent job (build)
    task automatic settle();
        while (cipher_out_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_column(logic [3:0] idx, col_t val);
        settle();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_BLANK_ONE)
        begin
            blank_one_reg = val;
            drop_board();
        end
        else if (idx == REG_BLANK_TWO)
        begin
            blank_two_reg = val;
            drop_board();
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [7:0] letter_symbol(int k);
        return $urandom_range(1) ? ASCII_LOWER_A + 8'(k) : ASCII_UPPER_A + 8'(k);
    endfunction

    // cipher digits of one letter, sent as decrypt items
    task automatic decrypt_letter(int k);
        int p;
        p = where_on_board[k];
        if (p >= ROW_WIDTH)
            send_item(OP_DEC, 8'((p < 2 * ROW_WIDTH) ? col_clip(blank_one_reg)
                                                    : col_clip(blank_two_reg)));
        send_item(OP_DEC, 8'(p % ROW_WIDTH));
    endtask

    task automatic run_session(int ops);
        int n_keys;
        int r;
        send_item(OP_CLEAR, 8'($urandom_range(255)));
        n_keys = ($urandom_range(99) < 70) ? $urandom_range(10) : $urandom_range(30);
        repeat (n_keys)
        begin
            if ($urandom_range(99) < 5)
                send_item(OP_LOAD, 8'($urandom_range(255)));
            else
                send_item(OP_LOAD, letter_symbol($urandom_range(LETTERS - 1)));
        end
        send_item(OP_BUILD, 8'($urandom_range(255)));
        repeat (ops)
        begin
            r = $urandom_range(99);
            if (r < 35)
                send_item(OP_ENC, letter_symbol($urandom_range(LETTERS - 1)));
            else if (r < 40)
                send_item(OP_ENC, 8'($urandom_range(255)));
            else if (r < 80 && board_ready)
                decrypt_letter($urandom_range(LETTERS - 1));
            else if (r < 90)
                send_item(OP_DEC, 8'($urandom_range(9)));
            else if (r < 95)
                send_item(OP_DEC, 8'($urandom_range(255)));
            else
                send_item(opcode_t'($urandom_range(7)), 8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_key();
        send_item(OP_ENC, "a");
        send_item(OP_DEC, 8'd3);
        send_item(OP_LOAD, "K");
        send_item(OP_LOAD, "e");
        send_item(OP_LOAD, "y");
        send_item(OP_LOAD, "k");
        send_item(OP_LOAD, "@");
        send_item(OP_LOAD, 8'hFF);
        send_item(OP_LOAD, "{");
        send_item(OP_LOAD, "Z");
        send_item(OP_BUILD, 8'h00);
        send_item(OP_ENC, "Z");
        send_item(OP_ENC, "m");
        send_item(OP_ENC, "x");
        send_item(OP_ENC, "5");
        send_item(OP_DEC, 8'd0);
        send_item(OP_DEC, 8'(RESET_COL_ONE));
        send_item(OP_DEC, 8'd0);
        // row two tail is pad
        send_item(OP_DEC, 8'(RESET_COL_TWO));
        send_item(OP_DEC, 8'd9);
        send_item(OP_DEC, 8'd12);
        // out-of-range digit drops the pending prefix
        send_item(OP_DEC, 8'(RESET_COL_ONE));
        send_item(OP_DEC, 8'd200);
        send_item(OP_DEC, 8'(RESET_COL_TWO));
        send_item(OP_DEC, 8'd5);
        send_item(3'd5, 8'hA5);
        send_item(3'd6, 8'h5A);
        send_item(3'd7, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_ENC, "k");
    endtask

    task automatic test_blank_columns();
        col_t ones [6] = '{4'd0, 4'd9, 4'd15, 4'd4, 4'd12, RESET_COL_ONE};
        col_t twos [6] = '{4'd9, 4'd0, 4'd1, 4'd4, 4'd14, RESET_COL_TWO};
        for (int i = 0; i < 6; i++)
        begin
            write_column(REG_BLANK_ONE, ones[i]);
            write_column(REG_BLANK_TWO, twos[i]);
            run_session(12);
        end
        // an unmapped index leaves the board intact
        write_column(4'hF, 4'hA);
        repeat (4)
            send_item(OP_ENC, letter_symbol($urandom_range(LETTERS - 1)));
        decrypt_letter($urandom_range(LETTERS - 1));
    endtask

    task automatic test_random_sessions();
        int n = 0;
        col_t a;
        col_t b;
        while (items_sent < RANDOM_ITEMS)
        begin
            steady = (n >= 3 && n < 7);
            if (n % 5 == 4)
            begin
                if ($urandom_range(99) < 70)
                begin
                    a = col_t'($urandom_range(9));
                    b = col_t'(($urandom_range(8) + a + 1) % ROW_WIDTH);
                end
                else
                begin
                    a = col_t'($urandom_range(15));
                    b = col_t'($urandom_range(15));
                end
                write_column(REG_BLANK_ONE, a);
                write_column(REG_BLANK_TWO, b);
            end
            else if (n % 6 == 1)
            begin
                while (cipher_out_q.size() != 0)
                    @(negedge clk);
            end
            run_session($urandom_range(15, 40));
            n++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        steady          = 1'b0;
        bad_count       = 0;
        items_sent      = 0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_LOAD;
        item_ch.symbol  = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_BLANK_ONE;
        cfg_ch.data     = 4'd0;
        result_ch.ready = 1'b0;
        blank_one_reg   = RESET_COL_ONE;
        blank_two_reg   = RESET_COL_TWO;
        used_mask       = '0;
        key_len         = 0;
        board_ready     = 1'b0;
        prefix_row      = 2'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_key();
        test_blank_columns();
        test_random_sessions();

        while (cipher_out_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_count == 0)
            $display("straddling_checkerboard_cipher_unit: match");
        else
            $display("straddling_checkerboard_cipher_unit: mismatch");
        $finish;
    end

    initial
    begin
        #4800000;
        $display("straddling_checkerboard_cipher_unit: mismatch");
        $finish;
    end

endmodule
